FILE: hw/rtl/mgt_pkg.sv
// ----------------------------------------------------------------------------
// mgt_pkg
// Shared types and codes for the multicast group table.
// ----------------------------------------------------------------------------
package mgt_pkg;

   localparam int IdW     = 16;
   localparam int StatusW = 2;

   localparam logic [StatusW-1:0] ST_JOINED   = 2'd0;
   localparam logic [StatusW-1:0] ST_FULL     = 2'd1;
   localparam logic [StatusW-1:0] ST_NO_ROOM  = 2'd2;
   localparam logic [StatusW-1:0] ST_DELIVERY = 2'd3;

   localparam logic FUNC_JOIN    = 1'b0;
   localparam logic FUNC_MESSAGE = 1'b1;

   // broadcast from the controller to every cell
   typedef struct packed {
      logic [IdW-1:0] grp;
      logic [IdW-1:0] client;
      logic           append;   // add client to the matching group
      logic           create;   // open a new group in the first free cell
   } cell_cmd_type;

endpackage

FILE: hw/rtl/mgt_cell.sv
// ----------------------------------------------------------------------------
// mgt_cell
// One group slot: group id, member list and member count. The in-use flag is
// handed to the next cell so that the first free slot finds itself.
// ----------------------------------------------------------------------------
module mgt_cell
   import mgt_pkg::*;
#(
   parameter int MEMBERS = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_cmd_type         cmd,
   input  logic                 prev_used,
   input  logic [(MEMBERS > 1 ? $clog2(MEMBERS) : 1)-1:0] rd_idx,
   output logic                 used,
   output logic                 hit,
   output logic                 full,
   output logic [MEMBERS-1:0]   neq_mask,
   output logic [IdW-1:0]       rd_member
);

   localparam int IW = (MEMBERS > 1) ? $clog2(MEMBERS) : 1;
   localparam int CW = $clog2(MEMBERS + 1);

   logic                 used_ff, used_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [IdW-1:0]       gid_ff, gid_in;
   logic [IdW-1:0]       members_ff [MEMBERS];
   logic [IdW-1:0]       members_in [MEMBERS];
   logic                 free;

   assign used = used_ff;
   assign hit  = used_ff && (gid_ff == cmd.grp);
   assign free = !used_ff && prev_used;
   assign full = (count_ff == CW'(MEMBERS));
   assign rd_member = members_ff[rd_idx];

   always_comb begin
      for (int k = 0; k < MEMBERS; k++) begin
         neq_mask[k] = (k < int'(count_ff)) && (members_ff[k] != cmd.client);
      end
   end

   always_comb begin
      used_in    = used_ff;
      count_in   = count_ff;
      gid_in     = gid_ff;
      members_in = members_ff;
      if (cmd.append && hit && !full) begin
         members_in[count_ff[IW-1:0]] = cmd.client;
         count_in = count_ff + CW'(1);
      end
      if (cmd.create && free) begin
         used_in       = 1'b1;
         gid_in        = cmd.grp;
         members_in[0] = cmd.client;
         count_in      = CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         used_ff  <= used_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      gid_ff     <= gid_in;
      members_ff <= members_in;
   end

endmodule

FILE: hw/rtl/multicast_group_table.sv
// ----------------------------------------------------------------------------
// multicast_group_table
// Multicast membership table built as a row of group cells.
// ----------------------------------------------------------------------------
// Holds up to GROUPS groups of up to MEMBERS clients, one group per cell.
// Groups fill the cells in creation order. A join holds the input from
// accept to the next accept: the lookup state compares all cells at once
// and, once the output register is free, loads the acknowledgement into it.
// A message holds it through the lookup state, then the controller walks
// the matched cell's member slots one per cycle while the output register
// is not stalled, up to the final delivery, sending a delivery word for
// every member other than the sender and flagging the final one with last,
// and then returns to idle. A message to an unknown group, or one whose
// only member is the sender, gives no word.
// ----------------------------------------------------------------------------
module multicast_group_table
   import mgt_pkg::*;
#(
   parameter int GROUPS  = 8,
   parameter int MEMBERS = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_func,
   input  logic [IdW-1:0]     req_group,
   input  logic [IdW-1:0]     req_client,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [StatusW-1:0] rsp_status,
   output logic [IdW-1:0]     rsp_ack_client,
   output logic [IdW-1:0]     rsp_dest_client,
   output logic               rsp_last
);

   localparam int IW = (MEMBERS > 1) ? $clog2(MEMBERS) : 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_FAN  = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic               func_ff, func_in;
   logic [IdW-1:0]     gid_ff, gid_in;
   logic [IdW-1:0]     cid_ff, cid_in;
   logic [MEMBERS-1:0] mask_ff, mask_in;
   logic [IW-1:0]      idx_ff, idx_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [StatusW-1:0] rsp_status_ff, rsp_status_in;
   logic [IdW-1:0]     rsp_ack_ff, rsp_ack_in;
   logic [IdW-1:0]     rsp_dest_ff, rsp_dest_in;
   logic               rsp_last_ff, rsp_last_in;

   cell_cmd_type       cmd;
   logic [GROUPS-1:0]  used, hit, full;
   logic [MEMBERS-1:0] cell_mask [GROUPS];
   logic [IdW-1:0]     cell_member [GROUPS];
   logic [MEMBERS-1:0] hit_mask;
   logic [IdW-1:0]     hit_member;
   logic               any_hit, any_full_hit, any_used_all, out_free;
   logic [MEMBERS-1:0] mask_clr;

   genvar gi;
   generate
      for (gi = 0; gi < GROUPS; gi++) begin : g_cell
         mgt_cell #(.MEMBERS(MEMBERS)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .cmd       (cmd),
            .prev_used ((gi == 0) ? 1'b1 : used[(gi == 0) ? 0 : gi - 1]),
            .rd_idx    (idx_ff),
            .used      (used[gi]),
            .hit       (hit[gi]),
            .full      (full[gi]),
            .neq_mask  (cell_mask[gi]),
            .rd_member (cell_member[gi])
         );
      end
   endgenerate

   always_comb begin
      hit_mask   = '0;
      hit_member = '0;
      for (int g = 0; g < GROUPS; g++) begin
         hit_mask   = hit_mask | (hit[g] ? cell_mask[g] : '0);
         hit_member = hit_member | (hit[g] ? cell_member[g] : '0);
      end
   end

   assign any_hit      = |hit;
   assign any_full_hit = |(hit & full);
   assign any_used_all = used[GROUPS-1];
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign mask_clr     = mask_ff & ~(MEMBERS'(1) << idx_ff);

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_ack_client  = rsp_ack_ff;
   assign rsp_dest_client = rsp_dest_ff;
   assign rsp_last        = rsp_last_ff;

   always_comb begin
      state_in      = state_ff;
      func_in       = func_ff;
      gid_in        = gid_ff;
      cid_in        = cid_ff;
      mask_in       = mask_ff;
      idx_in        = idx_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_ack_in    = rsp_ack_ff;
      rsp_dest_in   = rsp_dest_ff;
      rsp_last_in   = rsp_last_ff;
      cmd.grp       = gid_ff;
      cmd.client    = cid_ff;
      cmd.append    = 1'b0;
      cmd.create    = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               func_in  = req_func;
               gid_in   = req_group;
               cid_in   = req_client;
               state_in = S_LOOK;
            end
         end
         S_LOOK: begin
            if (func_ff == FUNC_JOIN) begin
               if (out_free) begin
                  cmd.append    = any_hit;
                  cmd.create    = !any_hit;
                  rsp_valid_in  = 1'b1;
                  rsp_ack_in    = cid_ff;
                  rsp_dest_in   = '0;
                  rsp_last_in   = 1'b1;
                  if (any_hit) begin
                     rsp_status_in = any_full_hit ? ST_FULL : ST_JOINED;
                  end else begin
                     rsp_status_in = any_used_all ? ST_NO_ROOM : ST_JOINED;
                  end
                  state_in = S_IDLE;
               end
            end else begin
               mask_in  = hit_mask;
               idx_in   = '0;
               state_in = S_FAN;
            end
         end
         S_FAN: begin
            if (mask_ff == '0) begin
               state_in = S_IDLE;
            end else if (!mask_ff[idx_ff]) begin
               idx_in = idx_ff + IW'(1);
            end else if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DELIVERY;
               rsp_ack_in    = '0;
               rsp_dest_in   = hit_member;
               rsp_last_in   = (mask_clr == '0);
               mask_in       = mask_clr;
               idx_in        = idx_ff + IW'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      gid_ff        <= gid_in;
      cid_ff        <= cid_in;
      mask_ff       <= mask_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_ack_ff    <= rsp_ack_in;
      rsp_dest_ff   <= rsp_dest_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule
